/* hdl/lzs_pkg.sv */
package lzs_pkg;

   localparam int BYTE_W                = 8;
   localparam int LEN_W                 = 32;
   localparam int STATUS_W              = 2;
   localparam int OUT_LANES             = 4;
   localparam int LANE_AW               = $clog2(OUT_LANES);
   localparam int FILL_W                = $clog2(OUT_LANES + 1);
   localparam int HISTORY_DEPTH_DEFAULT = 256;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_MARKER_VALUE    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_LENGTH = 1'd1;

   localparam logic [STATUS_W-1:0] STATUS_OK              = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TRUNCATED       = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_DISTANCE    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_LENGTH_MISMATCH = 2'd3;

   // request from the control path to close one result word
   typedef struct packed {
      logic                valid;
      logic                run_last;
      logic                stream_done;
      logic [STATUS_W-1:0] status;
   } lzs_flush_type;

endpackage

/* hdl/lzs_ram.sv */
module lzs_ram #(
   parameter int WIDTH = lzs_pkg::BYTE_W,
   parameter int DEPTH = lzs_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/lzs_packer.sv */
module lzs_packer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   input  logic [lzs_pkg::BYTE_W-1:0]   push_byte,
   input  lzs_pkg::lzs_flush_type       flush,
   output logic [lzs_pkg::FILL_W-1:0]   fill_count,
   output logic                         load_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [lzs_pkg::BYTE_W-1:0]   rsp_out_byte_0,
   output logic [lzs_pkg::BYTE_W-1:0]   rsp_out_byte_1,
   output logic [lzs_pkg::BYTE_W-1:0]   rsp_out_byte_2,
   output logic [lzs_pkg::BYTE_W-1:0]   rsp_out_byte_3,
   output logic [2:0]                   rsp_byte_count,
   output logic                         rsp_run_last,
   output logic                         rsp_stream_done,
   output logic [lzs_pkg::STATUS_W-1:0] rsp_status
);

   import lzs_pkg::*;

   logic [BYTE_W-1:0]   lane_ff [OUT_LANES];
   logic [BYTE_W-1:0]   lane_in [OUT_LANES];
   logic [FILL_W-1:0]   fill_ff, fill_in;

   logic [BYTE_W-1:0]   out_lane_ff [OUT_LANES];
   logic [BYTE_W-1:0]   out_lane_in [OUT_LANES];
   logic [FILL_W-1:0]   out_count_ff, out_count_in;
   logic                out_valid_ff, out_valid_in;
   logic                out_run_last_ff, out_run_last_in;
   logic                out_done_ff, out_done_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;

   assign load_ready = !out_valid_ff || !rsp_stall;
   assign fill_count = fill_ff;

   always_comb begin
      lane_in         = lane_ff;
      fill_in         = fill_ff;
      out_lane_in     = out_lane_ff;
      out_count_in    = out_count_ff;
      out_run_last_in = out_run_last_ff;
      out_done_in     = out_done_ff;
      out_status_in   = out_status_ff;
      out_valid_in    = out_valid_ff && rsp_stall;

      if (push_valid) begin
         lane_in[fill_ff[LANE_AW-1:0]] = push_byte;
         fill_in = fill_ff + 1'b1;
      end

      if (flush.valid) begin
         for (int j = 0; j < OUT_LANES; j++) begin
            out_lane_in[j] = (FILL_W'(j) < fill_ff) ? lane_ff[j] : '0;
         end
         out_count_in    = fill_ff;
         out_run_last_in = flush.run_last;
         out_done_in     = flush.stream_done;
         out_status_in   = flush.status;
         out_valid_in    = 1'b1;
         fill_in         = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
      lane_ff         <= lane_in;
      out_lane_ff     <= out_lane_in;
      out_count_ff    <= out_count_in;
      out_run_last_ff <= out_run_last_in;
      out_done_ff     <= out_done_in;
      out_status_ff   <= out_status_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte_0  = out_lane_ff[0];
   assign rsp_out_byte_1  = out_lane_ff[1];
   assign rsp_out_byte_2  = out_lane_ff[2];
   assign rsp_out_byte_3  = out_lane_ff[3];
   assign rsp_byte_count  = 3'(out_count_ff);
   assign rsp_run_last    = out_run_last_ff;
   assign rsp_stream_done = out_done_ff;
   assign rsp_status      = out_status_ff;

endmodule

/* hdl/lzs_marker_decompressor_core.sv */
// Order: a literal or escape byte is written to history and pushed into the packer on its
// transfer; a copy reads history, then writes and pushes each byte. A result word is closed
// when the four packer lanes are full, or at the end of an item that left bytes or ends the
// stream. A copy does one history read per cycle while the four-lane packer has room, and a
// result that waits on rsp_stall holds the core. Input is taken only between items.
// Reset: synchronous; clears token state, counters, the write pointer and both CSR registers; history kept.
module lzs_marker_decompressor_core #(
   parameter int HISTORY_DEPTH = lzs_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lzs_pkg::BYTE_W-1:0]     req_in_byte,
   input  logic                           req_end_of_stream,

   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lzs_pkg::BYTE_W-1:0]     rsp_out_byte_0,
   output logic [lzs_pkg::BYTE_W-1:0]     rsp_out_byte_1,
   output logic [lzs_pkg::BYTE_W-1:0]     rsp_out_byte_2,
   output logic [lzs_pkg::BYTE_W-1:0]     rsp_out_byte_3,
   output logic [2:0]                     rsp_byte_count,
   output logic                           rsp_run_last,
   output logic                           rsp_stream_done,
   output logic [lzs_pkg::STATUS_W-1:0]   rsp_status,

   input  logic                           csr_write_enable,
   input  logic [lzs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lzs_pkg::CSR_DATA_W-1:0] csr_write_data
);

   import lzs_pkg::*;

   localparam int AW = $clog2(HISTORY_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   typedef enum logic [2:0] {
      PH_PLAIN = 3'b001,
      PH_DIST  = 3'b010,
      PH_COUNT = 3'b100
   } phase_type;

   state_type           state_ff, state_in;
   phase_type           phase_ff, phase_in;
   logic [BYTE_W-1:0]   saved_ff, saved_in;
   logic [STATUS_W-1:0] error_ff, error_in;
   logic [LEN_W-1:0]    produced_ff, produced_in;
   logic [AW-1:0]       wp_ff, wp_in;
   logic                last_ff, last_in;
   logic [BYTE_W-1:0]   remaining_ff, remaining_in;
   logic [AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic                inflight_ff, fwd_ff, fwd_in;
   logic [BYTE_W-1:0]   last_byte_ff, last_byte_in;
   logic [BYTE_W-1:0]   marker_ff;
   logic [LEN_W-1:0]    expected_ff;

   logic                accept, is_marker, issue, final_cond;
   logic [BYTE_W-1:0]   dist_adj;
   logic [BYTE_W-1:0]   copy_byte, ram_rd_data;
   logic                lit_emit, emit_valid;
   logic [BYTE_W-1:0]   emit_byte;
   logic [FILL_W-1:0]   fill_count;
   logic                load_ready;
   logic [STATUS_W-1:0] end_status;
   lzs_flush_type       flush;

   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign is_marker  = (req_in_byte == marker_ff);
   assign dist_adj   = req_in_byte - BYTE_W'(req_in_byte > marker_ff);
   assign copy_byte  = fwd_ff ? last_byte_ff : ram_rd_data;

   // keep the read one slot ahead of the packer so arriving data always fits
   assign issue      = (state_ff == ST_RUN) && (remaining_ff != '0)
                       && ((fill_count + FILL_W'(inflight_ff)) < FILL_W'(OUT_LANES));
   assign final_cond = (state_ff == ST_RUN) && (remaining_ff == '0) && !inflight_ff;

   always_comb begin
      if (error_ff != STATUS_OK) begin
         end_status = error_ff;
      end else if (phase_ff != PH_PLAIN) begin
         end_status = STATUS_TRUNCATED;
      end else if (produced_ff != expected_ff) begin
         end_status = STATUS_LENGTH_MISMATCH;
      end else begin
         end_status = STATUS_OK;
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      saved_in     = saved_ff;
      error_in     = error_ff;
      produced_in  = produced_ff;
      wp_in        = wp_ff;
      last_in      = last_ff;
      remaining_in = remaining_ff;
      rd_ptr_in    = rd_ptr_ff;
      fwd_in       = 1'b0;
      last_byte_in = last_byte_ff;
      lit_emit     = 1'b0;
      flush        = '0;

      if (accept) begin
         state_in = ST_RUN;
         last_in  = req_end_of_stream;
         if (error_ff == STATUS_OK) begin
            case (phase_ff)
               PH_PLAIN: begin
                  if (is_marker) begin
                     phase_in = PH_DIST;
                  end else begin
                     lit_emit = 1'b1;
                  end
               end
               PH_DIST: begin
                  if (is_marker) begin
                     lit_emit = 1'b1;
                     phase_in = PH_PLAIN;
                  end else if (dist_adj == '0 || LEN_W'(dist_adj) > produced_ff) begin
                     error_in = STATUS_BAD_DISTANCE;
                     phase_in = PH_PLAIN;
                  end else begin
                     saved_in = dist_adj;
                     phase_in = PH_COUNT;
                  end
               end
               default: begin
                  remaining_in = req_in_byte;
                  rd_ptr_in    = wp_ff - AW'(saved_ff);
                  phase_in     = PH_PLAIN;
               end
            endcase
         end
      end

      if (issue) begin
         rd_ptr_in    = rd_ptr_ff + 1'b1;
         remaining_in = remaining_ff - 1'b1;
         // the entry is written this very cycle by the byte now arriving
         fwd_in       = inflight_ff && (rd_ptr_ff == wp_ff);
      end

      emit_valid = lit_emit || inflight_ff;
      emit_byte  = lit_emit ? req_in_byte : copy_byte;
      if (emit_valid) begin
         wp_in        = wp_ff + 1'b1;
         produced_in  = (produced_ff != '1) ? produced_ff + 1'b1 : produced_ff;
         last_byte_in = emit_byte;
      end

      if ((state_ff == ST_RUN) && !final_cond && (fill_count == FILL_W'(OUT_LANES))
          && load_ready) begin
         flush.valid = 1'b1;
      end

      if (final_cond) begin
         if (fill_count == '0 && !last_ff) begin
            state_in = ST_IDLE;
         end else if (load_ready) begin
            flush.valid       = 1'b1;
            flush.run_last    = 1'b1;
            flush.stream_done = last_ff;
            flush.status      = last_ff ? end_status : STATUS_OK;
            state_in          = ST_IDLE;
            if (last_ff) begin
               phase_in    = PH_PLAIN;
               saved_in    = '0;
               error_in    = STATUS_OK;
               produced_in = '0;
               wp_in       = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_PLAIN;
         saved_ff     <= '0;
         error_ff     <= STATUS_OK;
         produced_ff  <= '0;
         wp_ff        <= '0;
         last_ff      <= 1'b0;
         remaining_ff <= '0;
         inflight_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         marker_ff    <= '0;
         expected_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         saved_ff     <= saved_in;
         error_ff     <= error_in;
         produced_ff  <= produced_in;
         wp_ff        <= wp_in;
         last_ff      <= last_in;
         remaining_ff <= remaining_in;
         inflight_ff  <= issue;
         fwd_ff       <= fwd_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MARKER_VALUE:    marker_ff   <= csr_write_data[BYTE_W-1:0];
               CSR_EXPECTED_LENGTH: expected_ff <= csr_write_data[LEN_W-1:0];
               default: ;
            endcase
         end
      end
      rd_ptr_ff    <= rd_ptr_in;
      last_byte_ff <= last_byte_in;
   end

   lzs_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (emit_valid),
      .wr_addr (wp_ff),
      .wr_data (emit_byte),
      .rd_en   (issue),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   lzs_packer u_packer (
      .clock           (clock),
      .reset           (reset),
      .push_valid      (emit_valid),
      .push_byte       (emit_byte),
      .flush           (flush),
      .fill_count      (fill_count),
      .load_ready      (load_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte_0  (rsp_out_byte_0),
      .rsp_out_byte_1  (rsp_out_byte_1),
      .rsp_out_byte_2  (rsp_out_byte_2),
      .rsp_out_byte_3  (rsp_out_byte_3),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_done (rsp_stream_done),
      .rsp_status      (rsp_status)
   );

endmodule

/* hdl/lzs_checker.sv */
module lzs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [lzs_pkg::BYTE_W-1:0]   rsp_out_byte_3,
   input logic [2:0]                   rsp_byte_count,
   input logic                         rsp_run_last,
   input logic                         rsp_stream_done,
   input logic [lzs_pkg::STATUS_W-1:0] rsp_status
);

   import lzs_pkg::*;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_count <= 3'(OUT_LANES))
      else $error("byte count above lane count");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_done |-> rsp_run_last)
      else $error("stream end on a result that is not the last of its byte");

   // only the closing result may be empty or carry a status
   a_mid_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stream_done |-> rsp_status == STATUS_OK && rsp_byte_count != 3'd0)
      else $error("empty or flagged result before stream end");

   a_unused_lane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_count != 3'(OUT_LANES) |-> rsp_out_byte_3 == '0)
      else $error("unused lane not zero");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_byte_count))
      else $error("stalled result changed");

endmodule

bind lzs_marker_decompressor_core lzs_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte_3  (rsp_out_byte_3),
   .rsp_byte_count  (rsp_byte_count),
   .rsp_run_last    (rsp_run_last),
   .rsp_stream_done (rsp_stream_done),
   .rsp_status      (rsp_status)
);
